// ===== sv/triac_phase_angle_firing_assert.svh =====
// ----------------------------------------------------------------------------
// TRIAC firing controller assertion macros
// Concurrent assertion shorthands clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIAC_PHASE_ANGLE_FIRING_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_FIRING_ASSERT_SVH

// same-cycle implication
`define TPAF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tpaf assertion failed");

// next-cycle implication
`define TPAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tpaf assertion failed");

`endif

// ===== sv/tpaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared types and constants of the TRIAC phase-angle firing controller.
// ----------------------------------------------------------------------------
package tpaf_pkg;

    localparam int DELAY_W    = 16;
    localparam int TIMEOUT_W  = 17;
    localparam int COUNT_W    = 32;
    localparam int TEST_REM_W = 26;
    localparam int CFG_DATA_W = 17;

    localparam logic [DELAY_W-1:0]    PULSE_WIDTH_RST   = 16'd100;
    localparam logic [DELAY_W-1:0]    HALF_CYCLE_RST    = 16'd10000;
    localparam logic [DELAY_W-1:0]    MIN_FIRE_RST      = 16'd50;
    localparam logic [TIMEOUT_W-1:0]  ALIVE_TIMEOUT_RST = 17'd100000;
    localparam logic [DELAY_W-1:0]    FIRE_DELAY_RST    = 16'd10000;
    localparam logic [TEST_REM_W-1:0] TICKS_PER_MS      = 26'd1000;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ZERO_CROSS = 2'd1,
        OP_SET_DELAY  = 2'd2,
        OP_TEST       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_PULSE_WIDTH   = 2'd0,
        CFG_HALF_CYCLE    = 2'd1,
        CFG_MIN_FIRE      = 2'd2,
        CFG_ALIVE_TIMEOUT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DELAY_W-1:0]   pulse_width_us;
        logic [DELAY_W-1:0]   half_cycle_us;
        logic [DELAY_W-1:0]   min_fire_delay_us;
        logic [TIMEOUT_W-1:0] alive_timeout_us;
    } cfg_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [DELAY_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic               gate;
        logic               mains_alive;
        logic [COUNT_W-1:0] zero_cross_count;
        logic [DELAY_W-1:0] delay_in_use;
        logic               test_active;
    } result_t;

endpackage

// ===== sv/tpaf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpaf_cfg_regs
// Configuration register file, written through the plain write port.
// ----------------------------------------------------------------------------
module tpaf_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [tpaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tpaf_pkg::cfg_t                  cfg
);

    tpaf_pkg::cfg_t cfg_reg;
    tpaf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (tpaf_pkg::cfg_index_t'(cfg_index))
                tpaf_pkg::CFG_PULSE_WIDTH: begin
                    cfg_next.pulse_width_us = cfg_wdata[tpaf_pkg::DELAY_W-1:0];
                end
                tpaf_pkg::CFG_HALF_CYCLE: begin
                    cfg_next.half_cycle_us = cfg_wdata[tpaf_pkg::DELAY_W-1:0];
                end
                tpaf_pkg::CFG_MIN_FIRE: begin
                    cfg_next.min_fire_delay_us = cfg_wdata[tpaf_pkg::DELAY_W-1:0];
                end
                tpaf_pkg::CFG_ALIVE_TIMEOUT: begin
                    cfg_next.alive_timeout_us = cfg_wdata;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_width_us    <= tpaf_pkg::PULSE_WIDTH_RST;
            cfg_reg.half_cycle_us     <= tpaf_pkg::HALF_CYCLE_RST;
            cfg_reg.min_fire_delay_us <= tpaf_pkg::MIN_FIRE_RST;
            cfg_reg.alive_timeout_us  <= tpaf_pkg::ALIVE_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tpaf_in_stage.sv =====
// ----------------------------------------------------------------------------
// tpaf_in_stage
// Input register: captures one item per transfer, drains into the engine.
// ----------------------------------------------------------------------------
module tpaf_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [tpaf_pkg::DELAY_W-1:0] s_value,
    input  logic                         take,
    output logic                         item_valid,
    output tpaf_pkg::item_t              item
);

    logic            valid_reg;
    logic            valid_next;
    tpaf_pkg::item_t item_reg;
    logic            s_xfer;

    assign s_ready = !valid_reg || take;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_xfer) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.opcode <= tpaf_pkg::opcode_t'(s_opcode);
            item_reg.value  <= s_value;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/tpaf_engine.sv =====
// ----------------------------------------------------------------------------
// tpaf_engine
// Controller state, single-pass event update and result register.
// ----------------------------------------------------------------------------
module tpaf_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  tpaf_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  tpaf_pkg::item_t   item,
    output logic              take,
    input  logic              m_ready,
    output logic              m_valid,
    output tpaf_pkg::result_t result
);

    localparam int DW = tpaf_pkg::DELAY_W;
    localparam int TW = tpaf_pkg::TIMEOUT_W;
    localparam int CW = tpaf_pkg::COUNT_W;
    localparam int RW = tpaf_pkg::TEST_REM_W;

    logic [DW-1:0] fire_delay_reg,  fire_delay_next;
    logic [CW-1:0] count_reg,       count_next;
    logic [TW-1:0] since_reg,       since_next;
    logic [DW-1:0] fire_rem_reg,    fire_rem_next;
    logic          fire_armed_reg,  fire_armed_next;
    logic [DW-1:0] pulse_rem_reg,   pulse_rem_next;
    logic          pulse_armed_reg, pulse_armed_next;
    logic [RW-1:0] test_rem_reg,    test_rem_next;
    logic          test_mode_reg,   test_mode_next;
    logic          gate_reg,        gate_next;
    logic          res_valid_reg,   res_valid_next;
    tpaf_pkg::result_t result_reg,  result_next;
    logic          step;

    assign take = !res_valid_reg || m_ready;
    assign step = item_valid && take;

    always_comb begin
        fire_delay_next  = fire_delay_reg;
        count_next       = count_reg;
        since_next       = since_reg;
        fire_rem_next    = fire_rem_reg;
        fire_armed_next  = fire_armed_reg;
        pulse_rem_next   = pulse_rem_reg;
        pulse_armed_next = pulse_armed_reg;
        test_rem_next    = test_rem_reg;
        test_mode_next   = test_mode_reg;
        gate_next        = gate_reg;

        unique case (item.opcode)
            tpaf_pkg::OP_TICK: begin
                if (since_reg < cfg.alive_timeout_us) begin
                    since_next = since_reg + TW'(1);
                end
                // pulse countdown
                if (pulse_armed_reg) begin
                    if (pulse_rem_reg <= DW'(1)) begin
                        pulse_rem_next   = '0;
                        pulse_armed_next = 1'b0;
                        if (!test_mode_reg) begin
                            gate_next = 1'b0;
                        end
                    end else begin
                        pulse_rem_next = pulse_rem_reg - DW'(1);
                    end
                end
                // fire countdown; a new pulse overrides the pulse update
                if (fire_armed_reg) begin
                    if (fire_rem_reg <= DW'(1)) begin
                        fire_rem_next   = '0;
                        fire_armed_next = 1'b0;
                        if (!test_mode_reg) begin
                            gate_next        = 1'b1;
                            pulse_rem_next   = cfg.pulse_width_us;
                            pulse_armed_next = 1'b1;
                        end
                    end else begin
                        fire_rem_next = fire_rem_reg - DW'(1);
                    end
                end
                // test end
                if (test_mode_reg) begin
                    if (test_rem_reg <= RW'(1)) begin
                        test_rem_next  = '0;
                        test_mode_next = 1'b0;
                        gate_next      = 1'b0;
                    end else begin
                        test_rem_next = test_rem_reg - RW'(1);
                    end
                end
            end
            tpaf_pkg::OP_ZERO_CROSS: begin
                count_next = count_reg + CW'(1);
                since_next = '0;
                if (fire_delay_reg < cfg.half_cycle_us) begin
                    fire_rem_next   = (fire_delay_reg < cfg.min_fire_delay_us) ?
                                      cfg.min_fire_delay_us : fire_delay_reg;
                    fire_armed_next = 1'b1;
                end
            end
            tpaf_pkg::OP_SET_DELAY: begin
                fire_delay_next = (item.value > cfg.half_cycle_us) ?
                                  cfg.half_cycle_us : item.value;
            end
            tpaf_pkg::OP_TEST: begin
                fire_rem_next    = '0;
                fire_armed_next  = 1'b0;
                pulse_rem_next   = '0;
                pulse_armed_next = 1'b0;
                if (item.value == '0) begin
                    test_mode_next = 1'b0;
                    test_rem_next  = '0;
                    gate_next      = 1'b0;
                end else begin
                    test_mode_next = 1'b1;
                    test_rem_next  = RW'(item.value) * tpaf_pkg::TICKS_PER_MS;
                    gate_next      = 1'b1;
                end
            end
            default: begin
                gate_next = gate_reg;
            end
        endcase

        result_next.gate             = gate_next;
        result_next.mains_alive      = since_next < cfg.alive_timeout_us;
        result_next.zero_cross_count = count_next;
        result_next.delay_in_use     = fire_delay_next;
        result_next.test_active      = test_mode_next;

        res_valid_next = res_valid_reg;
        if (step) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_delay_reg  <= tpaf_pkg::FIRE_DELAY_RST;
            count_reg       <= '0;
            since_reg       <= '0;
            fire_rem_reg    <= '0;
            fire_armed_reg  <= 1'b0;
            pulse_rem_reg   <= '0;
            pulse_armed_reg <= 1'b0;
            test_rem_reg    <= '0;
            test_mode_reg   <= 1'b0;
            gate_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                fire_delay_reg  <= fire_delay_next;
                count_reg       <= count_next;
                since_reg       <= since_next;
                fire_rem_reg    <= fire_rem_next;
                fire_armed_reg  <= fire_armed_next;
                pulse_rem_reg   <= pulse_rem_next;
                pulse_armed_reg <= pulse_armed_next;
                test_rem_reg    <= test_rem_next;
                test_mode_reg   <= test_mode_next;
                gate_reg        <= gate_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign result  = result_reg;

endmodule

// ===== sv/triac_phase_angle_firing.sv =====
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// Phase-angle TRIAC gate controller driven by tick, zero-cross, delay and
// test events.
// Path: input register, then result register after a single update pass.
// Throughput: one item per cycle, set by the one-pass state update, while
// m_ready does not stall the result.
// Reset: synchronous, active low; state and registers take their defaults,
// both channels empty.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [tpaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_opcode,
    input  logic [tpaf_pkg::DELAY_W-1:0]    s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_gate,
    output logic                            m_mains_alive,
    output logic [tpaf_pkg::COUNT_W-1:0]    m_zero_cross_count,
    output logic [tpaf_pkg::DELAY_W-1:0]    m_delay_in_use,
    output logic                            m_test_active
);

    tpaf_pkg::cfg_t    cfg;
    tpaf_pkg::item_t   item;
    tpaf_pkg::result_t result;
    logic              item_valid;
    logic              take;

    tpaf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpaf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_value    (s_value),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tpaf_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result     (result)
    );

    assign m_gate             = result.gate;
    assign m_mains_alive      = result.mains_alive;
    assign m_zero_cross_count = result.zero_cross_count;
    assign m_delay_in_use     = result.delay_in_use;
    assign m_test_active      = result.test_active;

endmodule

// ===== sv/tpaf_checker.sv =====
// ----------------------------------------------------------------------------
// tpaf_checker
// Port-level assertions for the TRIAC firing controller, bound to the top.
// ----------------------------------------------------------------------------
`include "triac_phase_angle_firing_assert.svh"

module tpaf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_gate,
    input logic                         m_mains_alive,
    input logic [tpaf_pkg::COUNT_W-1:0] m_zero_cross_count,
    input logic [tpaf_pkg::DELAY_W-1:0] m_delay_in_use,
    input logic                         m_test_active
);

    // stalled result transfer holds
    `TPAF_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_gate) && $stable(m_mains_alive)
        && $stable(m_zero_cross_count) && $stable(m_delay_in_use) && $stable(m_test_active))

    // test mode always drives the gate
    `TPAF_ASSERT_NOW(a_test_gate, m_valid && m_test_active, m_gate)

    // a ready sink never stalls the source
    `TPAF_ASSERT_NOW(a_no_stall, m_ready, s_ready)

    // no result straight out of reset
    `TPAF_ASSERT_NOW(a_reset_empty, !$past(aresetn), !m_valid)

endmodule

bind triac_phase_angle_firing tpaf_checker u_tpaf_checker (.*);
